FILE: sv/pss_pkg.sv
package pss_pkg;

  localparam int MAX_POURS   = 16;
  localparam int RATIO_SCALE = 1000;

  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int COFFEE_W  = 20;
  localparam int RATIO_W   = 16;
  localparam int MS_W      = 24;
  localparam int TIME_W    = 32;
  localparam int REM_T_W   = 25;
  localparam int WEIGHT_W  = 24;
  localparam int REM_W_W   = 32;
  localparam int CT_W      = 32;
  localparam int CFG_IDX_W = 1;

  // Coffee dose split as coffee = A * RATIO_SCALE + B, so that a pour weight is
  // ratio * A + floor(ratio * B / RATIO_SCALE).
  localparam int A_W  = COFFEE_W;
  localparam int B_W  = RATIO_W;
  localparam int X_W  = RATIO_W + B_W;
  localparam int PW_W = RATIO_W + A_W;
  localparam int RW_W = PW_W + 2;

  // Rounded-up reciprocals; the quotient estimate is exact or one too large.
  localparam logic [COFFEE_W:0] RECIP_C =
      (COFFEE_W+1)'(((64'd1 << COFFEE_W) + 64'(RATIO_SCALE) - 64'd1) / 64'(RATIO_SCALE));
  localparam logic [X_W:0] RECIP_X =
      (X_W+1)'(((64'd1 << X_W) + 64'(RATIO_SCALE) - 64'd1) / 64'(RATIO_SCALE));

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POUR_COUNT = 1'b0,
    CFG_COFFEE     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [MS_W-1:0]    pour_ms;
    logic [MS_W-1:0]    pause_ms;
    logic [RATIO_W-1:0] ratio;
    logic               auto_start;
    logic               auto_adv;
  } entry_t;

  typedef struct packed {
    logic               tare;
    logic               buzz;
    logic [REM_T_W-1:0] rem_time;
    logic               pause;
    logic [IDX_W-1:0]   idx;
    logic               step_fwd;
  } res_t;

  typedef struct packed {
    res_t                res;
    logic [WEIGHT_W-1:0] weight;
    logic                adv;
    logic                clr;
  } tail_t;

endpackage

FILE: sv/pour_step_sequencer_unit.sv
// Throughput: one item per cycle unless the output stalls with every stage full.
// An input transfer runs through stages s1 to s6 into the output register;
// the tick state (current pour, start time, phase flags) updates with each item.
// Reset: asynchronous, active low; clears the sequencer state, the pipeline valids
// and the registers (pour count 1, coffee dose 0). The pour table is undefined until
// written and is not cleared.
module pour_step_sequencer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         command_i,
  input  logic [pss_pkg::TIME_W-1:0]         now_ms_i,
  input  logic                               encoder_turned_i,
  input  logic                               encoder_click_i,
  input  logic signed [pss_pkg::WEIGHT_W-1:0] weight_mg_i,
  input  logic [pss_pkg::IDX_W-1:0]          entry_index_i,
  input  logic [pss_pkg::MS_W-1:0]           entry_pour_ms_i,
  input  logic [pss_pkg::MS_W-1:0]           entry_pause_ms_i,
  input  logic [pss_pkg::RATIO_W-1:0]        entry_ratio_i,
  input  logic                               entry_auto_start_i,
  input  logic                               entry_auto_advance_i,

  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               tare_request_o,
  output logic                               buzzer_pulse_o,
  output logic signed [pss_pkg::REM_W_W-1:0] remaining_weight_mg_o,
  output logic [pss_pkg::REM_T_W-1:0]        remaining_time_ms_o,
  output logic                               in_pause_o,
  output logic [pss_pkg::IDX_W-1:0]          pour_index_o,
  output logic                               may_step_forward_o,

  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pss_pkg::COFFEE_W-1:0]       cfg_data_i
);
  import pss_pkg::*;

  function automatic logic [X_W-1:0] quot_est(input logic [X_W-1:0] x);
    logic [2*X_W:0] prod;
    prod = (2*X_W+1)'(x) * (2*X_W+1)'(RECIP_X);
    return prod[X_W +: X_W];
  endfunction

  function automatic logic [X_W-1:0] quot_fix(input logic [X_W-1:0] x,
                                              input logic [X_W-1:0] q0);
    logic [X_W+B_W-1:0] back;
    back = (X_W+B_W)'(q0) * (X_W+B_W)'(RATIO_SCALE);
    return (back > (X_W+B_W)'(x)) ? q0 - X_W'(1) : q0;
  endfunction

  // ---------------------------------------------------------------- registers
  logic [CNT_W-1:0]    pour_count_q;
  logic [COFFEE_W-1:0] coffee_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pour_count_q <= CNT_W'(1);
      coffee_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POUR_COUNT: pour_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_COFFEE:     coffee_q     <= cfg_data_i;
      endcase
    end
  end

  // Split of the dose, registered in a0_q and c1_q and then in a_q and b_q after a
  // write. An item passes s1 and s2 before it reaches the weight multipliers.
  logic [2*COFFEE_W:0]    c_prod;
  logic [A_W-1:0]         a0_q, a_q;
  logic [COFFEE_W-1:0]    c1_q;
  logic [B_W-1:0]         b_q;
  logic [A_W+B_W-1:0]     a0_back;
  logic                   a0_over;
  logic [A_W+B_W-1:0]     b_full;

  assign c_prod  = (2*COFFEE_W+1)'(coffee_q) * (2*COFFEE_W+1)'(RECIP_C);
  assign a0_back = (A_W+B_W)'(a0_q) * (A_W+B_W)'(RATIO_SCALE);
  assign a0_over = a0_back > (A_W+B_W)'(c1_q);
  assign b_full  = (A_W+B_W)'(c1_q) - a0_back
                 + (a0_over ? (A_W+B_W)'(RATIO_SCALE) : '0);

  always_ff @(posedge clk_i) begin
    a0_q <= c_prod[COFFEE_W +: A_W];
    c1_q <= coffee_q;
    a_q  <= a0_over ? a0_q - A_W'(1) : a0_q;
    b_q  <= b_full[B_W-1:0];
  end

  // ---------------------------------------------------------------- flow control
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, out_v_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_o;
  logic accept;

  assign rdy_o  = !out_v_q || !out_stall_i;
  assign rdy6   = !s6_v_q || rdy_o;
  assign rdy5   = !s5_v_q || rdy6;
  assign rdy4   = !s4_v_q || rdy5;
  assign rdy3   = !s3_v_q || rdy4;
  assign rdy2   = !s2_v_q || rdy3;
  assign rdy1   = !s1_v_q || rdy2;
  assign accept = in_valid_i && rdy1;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1)  s1_v_q  <= in_valid_i;
      if (rdy2)  s2_v_q  <= s1_v_q;
      if (rdy3)  s3_v_q  <= s2_v_q;
      if (rdy4)  s4_v_q  <= s3_v_q;
      if (rdy5)  s5_v_q  <= s4_v_q;
      if (rdy6)  s6_v_q  <= s5_v_q;
      if (rdy_o) out_v_q <= s6_v_q;
    end
  end

  // ---------------------------------------------------------------- pour table
  entry_t tab_q [MAX_POURS];
  entry_t entry_q;  // table entry of the current pour
  entry_t wr_entry;
  logic   wr_en;

  assign wr_entry = '{pour_ms:    entry_pour_ms_i,
                      pause_ms:   entry_pause_ms_i,
                      ratio:      entry_ratio_i,
                      auto_start: entry_auto_start_i,
                      auto_adv:   entry_auto_advance_i};
  assign wr_en = accept && (command_i == CMD_WRITE) && (int'(entry_index_i) < MAX_POURS);

  // ---------------------------------------------------------------- tick logic
  logic [IDX_W-1:0]   cur_q, cur_d;
  logic               started_q, started_d;
  logic [TIME_W-1:0]  start_q, start_d;
  logic               done_q, done_d;

  logic               as_fire, started_eff, done_hit, can_adv, adv, clr;
  logic [TIME_W-1:0]  start_eff, passed;
  logic [REM_T_W-1:0] sum_ms;
  logic [CNT_W-1:0]   limit;
  res_t               res1;

  assign limit   = (pour_count_q > CNT_W'(MAX_POURS)) ? CNT_W'(MAX_POURS) : pour_count_q;
  assign can_adv = ({1'b0, cur_q} + CNT_W'(1)) < limit;

  always_comb begin
    cur_d       = cur_q;
    started_d   = started_q;
    start_d     = start_q;
    done_d      = done_q;
    adv         = 1'b0;
    clr         = 1'b0;
    done_hit    = 1'b0;
    as_fire     = !started_q && entry_q.auto_start;
    started_eff = started_q || as_fire;
    start_eff   = as_fire ? now_ms_i : start_q;
    passed      = now_ms_i - start_eff;
    sum_ms      = REM_T_W'(entry_q.pour_ms) + REM_T_W'(entry_q.pause_ms);
    res1        = '0;
    unique case (cmd_e'(command_i))
      CMD_TICK: begin
        res1.tare = encoder_turned_i;
        started_d = started_eff;
        start_d   = start_eff;
        if (!started_eff) begin
          res1.rem_time = (entry_q.pour_ms != '0) ? REM_T_W'(entry_q.pour_ms)
                                                  : REM_T_W'(entry_q.pause_ms);
          // A click that starts the pour is used up by the start.
          if (encoder_click_i) begin
            started_d = 1'b1;
            start_d   = now_ms_i;
          end
        end else if (passed < TIME_W'(entry_q.pour_ms)) begin
          res1.rem_time = REM_T_W'(entry_q.pour_ms - passed[MS_W-1:0]);
        end else if (passed < TIME_W'(sum_ms)) begin
          res1.rem_time = sum_ms - passed[REM_T_W-1:0];
          res1.pause    = 1'b1;
        end else begin
          done_hit = 1'b1;
        end
        res1.buzz = done_hit && !done_q;
        adv = can_adv && started_eff && ((done_hit && entry_q.auto_adv) || encoder_click_i);
        if (adv) begin
          cur_d     = cur_q + IDX_W'(1);
          started_d = 1'b0;
          done_d    = 1'b0;
        end else begin
          done_d = done_q || done_hit;
        end
      end
      CMD_RESTART: begin
        cur_d     = '0;
        started_d = 1'b0;
        start_d   = '0;
        done_d    = 1'b0;
        clr       = 1'b1;
      end
      default: begin
      end
    endcase
    res1.idx      = cur_d;
    res1.step_fwd = (({1'b0, cur_d} + CNT_W'(1)) >= pour_count_q) && done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      started_q <= 1'b0;
      start_q   <= '0;
      done_q    <= 1'b0;
    end else if (accept) begin
      cur_q     <= cur_d;
      started_q <= started_d;
      start_q   <= start_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tab_q[entry_index_i] <= wr_entry;
    end
    if (accept) begin
      entry_q <= (wr_en && (entry_index_i == cur_d)) ? wr_entry : tab_q[cur_d];
    end
  end

  // ---------------------------------------------------------------- weight pipeline
  tail_t              s1_tail_q, s2_tail_q, s3_tail_q, s4_tail_q, s5_tail_q, s6_tail_q;
  logic [RATIO_W-1:0] s1_r_old_q, s2_r_old_q, s2_r_new_q;
  logic [PW_W-1:0]    s3_ra_old_q, s3_ra_new_q, s4_ra_old_q, s4_ra_new_q;
  logic [X_W-1:0]     s3_x_old_q, s3_x_new_q, s4_x_old_q, s4_x_new_q;
  logic [X_W-1:0]     s4_q_old_q, s4_q_new_q;
  logic [PW_W-1:0]    s5_w_old_q, s5_w_new_q, s6_w_new_q;
  logic [CT_W-1:0]    ct_q, ct_next, s6_ct_q;
  logic [PW_W:0]      ct_sum;

  // Completed target through the previous pour, updated in item order.
  assign ct_sum  = (PW_W+1)'(ct_q) + (PW_W+1)'(s5_w_old_q);
  always_comb begin
    ct_next = ct_q;
    if (s5_tail_q.clr) begin
      ct_next = '0;
    end else if (s5_tail_q.adv) begin
      ct_next = (ct_sum[PW_W:CT_W] != '0) ? '1 : ct_sum[CT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ct_q <= '0;
    end else if (s5_v_q && rdy6) begin
      ct_q <= ct_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_tail_q  <= '{res: res1, weight: weight_mg_i, adv: adv, clr: clr};
      s1_r_old_q <= entry_q.ratio;
    end
    if (rdy2) begin
      s2_tail_q  <= s1_tail_q;
      s2_r_old_q <= s1_r_old_q;
      s2_r_new_q <= entry_q.ratio;
    end
    if (rdy3) begin
      s3_tail_q   <= s2_tail_q;
      s3_ra_old_q <= PW_W'(s2_r_old_q) * PW_W'(a_q);
      s3_ra_new_q <= PW_W'(s2_r_new_q) * PW_W'(a_q);
      s3_x_old_q  <= X_W'(s2_r_old_q) * X_W'(b_q);
      s3_x_new_q  <= X_W'(s2_r_new_q) * X_W'(b_q);
    end
    if (rdy4) begin
      s4_tail_q   <= s3_tail_q;
      s4_ra_old_q <= s3_ra_old_q;
      s4_ra_new_q <= s3_ra_new_q;
      s4_x_old_q  <= s3_x_old_q;
      s4_x_new_q  <= s3_x_new_q;
      s4_q_old_q  <= quot_est(s3_x_old_q);
      s4_q_new_q  <= quot_est(s3_x_new_q);
    end
    if (rdy5) begin
      s5_tail_q  <= s4_tail_q;
      s5_w_old_q <= s4_ra_old_q + PW_W'(quot_fix(s4_x_old_q, s4_q_old_q));
      s5_w_new_q <= s4_ra_new_q + PW_W'(quot_fix(s4_x_new_q, s4_q_new_q));
    end
    if (rdy6) begin
      s6_tail_q  <= s5_tail_q;
      s6_ct_q    <= ct_next;
      s6_w_new_q <= s5_w_new_q;
    end
  end

  // ---------------------------------------------------------------- result register
  logic signed [RW_W-1:0]    rem_full;
  logic signed [REM_W_W-1:0] rem_sat;

  assign rem_full = $signed(RW_W'(s6_ct_q)) + $signed(RW_W'(s6_w_new_q))
                  - $signed({{(RW_W-WEIGHT_W){s6_tail_q.weight[WEIGHT_W-1]}},
                             s6_tail_q.weight});

  always_comb begin
    if (rem_full[RW_W-1:REM_W_W-1] == '0 || rem_full[RW_W-1:REM_W_W-1] == '1) begin
      rem_sat = rem_full[REM_W_W-1:0];
    end else if (rem_full[RW_W-1]) begin
      rem_sat = {1'b1, {(REM_W_W-1){1'b0}}};
    end else begin
      rem_sat = {1'b0, {(REM_W_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      tare_request_o        <= s6_tail_q.res.tare;
      buzzer_pulse_o        <= s6_tail_q.res.buzz;
      remaining_weight_mg_o <= rem_sat;
      remaining_time_ms_o   <= s6_tail_q.res.rem_time;
      in_pause_o            <= s6_tail_q.res.pause;
      pour_index_o          <= s6_tail_q.res.idx;
      may_step_forward_o    <= s6_tail_q.res.step_fwd;
    end
  end

  // ---------------------------------------------------------------- assertions
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_v_q && s2_v_q && s3_v_q && s4_v_q && s5_v_q && s6_v_q &&
                    out_v_q && out_stall_i))
    else $error("input stalled while the pipeline has a free stage");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_RESTART) |=> (cur_q == '0 && !started_q && !done_q))
    else $error("restart did not return to the first pour");

  a_advance_steps_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && adv) |=> (cur_q == $past(cur_q) + IDX_W'(1) && !started_q && !done_q))
    else $error("advance did not move to the next pour cleanly");

  a_target_moves_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s5_v_q && rdy6) |=> $stable(ct_q))
    else $error("completed target changed without an item transfer");

endmodule

FILE: dv/pss_checker.sv
`timescale 1ns / 100ps

// Watches the input, output and register channels of the pour step sequencer,
// keeps its own model of the sequencer state and compares every output transfer
// with the oldest predicted readout.
module pss_checker
  import pss_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [1:0]                  command_i,
  input  logic [TIME_W-1:0]           now_ms_i,
  input  logic                        encoder_turned_i,
  input  logic                        encoder_click_i,
  input  logic signed [WEIGHT_W-1:0]  weight_mg_i,
  input  logic [IDX_W-1:0]            entry_index_i,
  input  logic [MS_W-1:0]             entry_pour_ms_i,
  input  logic [MS_W-1:0]             entry_pause_ms_i,
  input  logic [RATIO_W-1:0]          entry_ratio_i,
  input  logic                        entry_auto_start_i,
  input  logic                        entry_auto_advance_i,

  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic                        tare_request_i,
  input  logic                        buzzer_pulse_i,
  input  logic signed [REM_W_W-1:0]   remaining_weight_mg_i,
  input  logic [REM_T_W-1:0]          remaining_time_ms_i,
  input  logic                        in_pause_i,
  input  logic [IDX_W-1:0]            pour_index_i,
  input  logic                        may_step_forward_i,

  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [COFFEE_W-1:0]         cfg_data_i,

  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o
);

  localparam int MAX_PRINTS = 100;
  localparam longint REM_MAX = 64'sd2147483647;
  localparam longint REM_MIN = -64'sd2147483648;

  typedef struct {
    logic                      tare;
    logic                      buzz;
    logic signed [REM_W_W-1:0] rem_weight;
    logic [REM_T_W-1:0]        rem_time;
    logic                      pause;
    logic [IDX_W-1:0]          idx;
    logic                      step_fwd;
  } readout_t;

  readout_t due_readouts[$];

  logic [MS_W-1:0]     tbl_pour_ms   [MAX_POURS];
  logic [MS_W-1:0]     tbl_pause_ms  [MAX_POURS];
  logic [RATIO_W-1:0]  tbl_ratio     [MAX_POURS];
  logic                tbl_auto_start[MAX_POURS];
  logic                tbl_auto_adv  [MAX_POURS];

  logic [IDX_W-1:0]    active_step;
  logic                step_running;
  logic                step_finished;
  logic [TIME_W-1:0]   step_t0;
  logic [CT_W-1:0]     banked_mg;

  logic [CNT_W-1:0]    cfg_steps;
  logic [COFFEE_W-1:0] cfg_dose;

  int fails;
  int checked;

  task automatic report(input string msg);
    fails++;
    if (fails <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want)
      report($sformatf("readout %0d: %s is %0d, expected %0d", checked, name, got, want));
  endtask

  function automatic longint unsigned step_target_mg(input logic [IDX_W-1:0] i);
    longint unsigned r;
    longint unsigned d;
    r = tbl_ratio[i];
    d = cfg_dose;
    return (r * d) / RATIO_SCALE;
  endfunction

  task automatic move_to_next_step();
    int lim;
    longint unsigned sum;
    lim = (int'(cfg_steps) < MAX_POURS) ? int'(cfg_steps) : MAX_POURS;
    if (int'(active_step) + 1 < lim) begin
      sum = longint'(banked_mg) + step_target_mg(active_step);
      banked_mg = (sum > 64'hFFFF_FFFF) ? '1 : sum[CT_W-1:0];
      active_step++;
      step_running = 1'b0;
      step_finished = 1'b0;
    end
  endtask

  task automatic clear_sequence();
    active_step = '0;
    step_running = 1'b0;
    step_t0 = '0;
    step_finished = 1'b0;
    banked_mg = '0;
  endtask

  // Applies one accepted input transfer to the model and queues its readout.
  task automatic sequence_step();
    readout_t e;
    logic click;
    logic adv;
    logic [TIME_W-1:0] passed;
    logic [TIME_W-1:0] p_ms;
    logic [TIME_W-1:0] z_ms;
    longint total;
    longint rem;
    longint w;
    e = '{default: '0};
    click = encoder_click_i;
    // The entry is read before any advance can move the index.
    p_ms = TIME_W'(tbl_pour_ms[active_step]);
    z_ms = TIME_W'(tbl_pause_ms[active_step]);
    adv = tbl_auto_adv[active_step];
    case (command_i)
      CMD_TICK: begin
        e.tare = encoder_turned_i;
        if (!step_running && tbl_auto_start[active_step]) begin
          step_running = 1'b1;
          step_t0 = now_ms_i;
        end
        passed = now_ms_i - step_t0;
        if (!step_running) begin
          e.rem_time = REM_T_W'((p_ms != 0) ? p_ms : z_ms);
          // A click that starts the pour is used up here and does not advance.
          if (click) begin
            step_running = 1'b1;
            step_t0 = now_ms_i;
            click = 1'b0;
          end
        end else if (passed < p_ms) begin
          e.rem_time = REM_T_W'(p_ms - passed);
        end else if (passed < p_ms + z_ms) begin
          e.rem_time = REM_T_W'(p_ms + z_ms - passed);
          e.pause = 1'b1;
        end else begin
          if (!step_finished) begin
            step_finished = 1'b1;
            e.buzz = 1'b1;
          end
          if (adv) move_to_next_step();
        end
        if (step_running && click) move_to_next_step();
      end
      CMD_WRITE: begin
        tbl_pour_ms[entry_index_i] = entry_pour_ms_i;
        tbl_pause_ms[entry_index_i] = entry_pause_ms_i;
        tbl_ratio[entry_index_i] = entry_ratio_i;
        tbl_auto_start[entry_index_i] = entry_auto_start_i;
        tbl_auto_adv[entry_index_i] = entry_auto_advance_i;
      end
      CMD_RESTART: clear_sequence();
      default: ;
    endcase
    total = longint'(banked_mg) + longint'(step_target_mg(active_step));
    w = weight_mg_i;
    rem = total - w;
    if (rem > REM_MAX) rem = REM_MAX;
    if (rem < REM_MIN) rem = REM_MIN;
    e.rem_weight = rem[REM_W_W-1:0];
    e.idx = active_step;
    e.step_fwd = (int'(active_step) + 1 >= int'(cfg_steps)) && step_finished;
    due_readouts.push_back(e);
  endtask

  task automatic check_readout();
    readout_t e;
    if (due_readouts.size() == 0) begin
      report("output transfer with no readout expected");
      return;
    end
    e = due_readouts.pop_front();
    check_field("tare_request", tare_request_i, e.tare);
    check_field("buzzer_pulse", buzzer_pulse_i, e.buzz);
    check_field("remaining_weight_mg", remaining_weight_mg_i, e.rem_weight);
    check_field("remaining_time_ms", remaining_time_ms_i, e.rem_time);
    check_field("in_pause", in_pause_i, e.pause);
    check_field("pour_index", pour_index_i, e.idx);
    check_field("may_step_forward", may_step_forward_i, e.step_fwd);
    checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_sequence();
      cfg_steps = CNT_W'(1);
      cfg_dose = '0;
      due_readouts.delete();
      for (int i = 0; i < MAX_POURS; i++) begin
        tbl_pour_ms[i] = '0;
        tbl_pause_ms[i] = '0;
        tbl_ratio[i] = '0;
        tbl_auto_start[i] = 1'b0;
        tbl_auto_adv[i] = 1'b0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_POUR_COUNT) cfg_steps = cfg_data_i[CNT_W-1:0];
        else cfg_dose = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) check_readout();
      if (in_valid_i && !in_stall_i) sequence_step();
    end
    fail_count_o <= fails;
    pending_o <= due_readouts.size();
    checked_o <= checked;
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import pss_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 200;
  localparam int PHASES        = 7;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic [1:0]                 cmd;
    logic [TIME_W-1:0]          now;
    logic                       turned;
    logic                       click;
    logic signed [WEIGHT_W-1:0] weight;
    logic [IDX_W-1:0]           slot;
    logic [MS_W-1:0]            pour_ms;
    logic [MS_W-1:0]            pause_ms;
    logic [RATIO_W-1:0]         ratio;
    logic                       auto_start;
    logic                       auto_adv;
  } pour_item_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                       in_valid;
  logic                       in_stall;
  logic [1:0]                 command;
  logic [TIME_W-1:0]          now_ms;
  logic                       encoder_turned;
  logic                       encoder_click;
  logic signed [WEIGHT_W-1:0] weight_mg;
  logic [IDX_W-1:0]           entry_index;
  logic [MS_W-1:0]            entry_pour_ms;
  logic [MS_W-1:0]            entry_pause_ms;
  logic [RATIO_W-1:0]         entry_ratio;
  logic                       entry_auto_start;
  logic                       entry_auto_advance;

  logic                       out_valid;
  logic                       out_stall;
  logic                       tare_request;
  logic                       buzzer_pulse;
  logic signed [REM_W_W-1:0]  remaining_weight_mg;
  logic [REM_T_W-1:0]         remaining_time_ms;
  logic                       in_pause;
  logic [IDX_W-1:0]           pour_index;
  logic                       may_step_forward;

  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [COFFEE_W-1:0]        cfg_data;

  int fail_count;
  int pending;
  int checked;

  int cycles = 0;
  int sent = 0;
  int n_ticks = 0;
  int n_writes = 0;
  int n_restarts = 0;
  int n_unused = 0;
  int n_settings = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pour_step_sequencer_unit DUT (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .command_i             (command),
    .now_ms_i              (now_ms),
    .encoder_turned_i      (encoder_turned),
    .encoder_click_i       (encoder_click),
    .weight_mg_i           (weight_mg),
    .entry_index_i         (entry_index),
    .entry_pour_ms_i       (entry_pour_ms),
    .entry_pause_ms_i      (entry_pause_ms),
    .entry_ratio_i         (entry_ratio),
    .entry_auto_start_i    (entry_auto_start),
    .entry_auto_advance_i  (entry_auto_advance),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .tare_request_o        (tare_request),
    .buzzer_pulse_o        (buzzer_pulse),
    .remaining_weight_mg_o (remaining_weight_mg),
    .remaining_time_ms_o   (remaining_time_ms),
    .in_pause_o            (in_pause),
    .pour_index_o          (pour_index),
    .may_step_forward_o    (may_step_forward),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data)
  );

  pss_checker u_checker (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_stall_i            (in_stall),
    .command_i             (command),
    .now_ms_i              (now_ms),
    .encoder_turned_i      (encoder_turned),
    .encoder_click_i       (encoder_click),
    .weight_mg_i           (weight_mg),
    .entry_index_i         (entry_index),
    .entry_pour_ms_i       (entry_pour_ms),
    .entry_pause_ms_i      (entry_pause_ms),
    .entry_ratio_i         (entry_ratio),
    .entry_auto_start_i    (entry_auto_start),
    .entry_auto_advance_i  (entry_auto_advance),
    .out_valid_i           (out_valid),
    .out_stall_i           (out_stall),
    .tare_request_i        (tare_request),
    .buzzer_pulse_i        (buzzer_pulse),
    .remaining_weight_mg_i (remaining_weight_mg),
    .remaining_time_ms_i   (remaining_time_ms),
    .in_pause_i            (in_pause),
    .pour_index_i          (pour_index),
    .may_step_forward_i    (may_step_forward),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_i           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data),
    .fail_count_o          (fail_count),
    .pending_o             (pending),
    .checked_o             (checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic pour_item_t random_item();
    pour_item_t it;
    it.cmd = CMD_TICK;
    it.now = $urandom;
    it.turned = $urandom_range(0, 1);
    it.click = $urandom_range(0, 1);
    it.weight = $urandom;
    it.slot = $urandom;
    it.pour_ms = $urandom;
    it.pause_ms = $urandom;
    it.ratio = $urandom;
    it.auto_start = $urandom_range(0, 1);
    it.auto_adv = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] random_weight();
    int w;
    if ($urandom_range(0, 3) == 0) w = $urandom;
    else w = int'($urandom_range(0, 200000)) - 50000;
    return w[WEIGHT_W-1:0];
  endfunction

  // Offers one item after a random gap and returns in the step of its transfer,
  // so that the next call either lowers valid or replaces the payload.
  task automatic send_item(input pour_item_t it);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command <= it.cmd;
    now_ms <= it.now;
    encoder_turned <= it.turned;
    encoder_click <= it.click;
    weight_mg <= it.weight;
    entry_index <= it.slot;
    entry_pour_ms <= it.pour_ms;
    entry_pause_ms <= it.pause_ms;
    entry_ratio <= it.ratio;
    entry_auto_start <= it.auto_start;
    entry_auto_advance <= it.auto_adv;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    if (sent % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    case (it.cmd)
      CMD_TICK:    n_ticks++;
      CMD_WRITE:   n_writes++;
      CMD_RESTART: n_restarts++;
      default:     n_unused++;
    endcase
  endtask

  task automatic send_tick(input logic [TIME_W-1:0] t, input logic click,
                           input logic signed [WEIGHT_W-1:0] w);
    pour_item_t it;
    it = random_item();
    it.cmd = CMD_TICK;
    it.now = t;
    it.click = click;
    it.weight = w;
    send_item(it);
  endtask

  task automatic send_entry(input logic [IDX_W-1:0] slot, input logic [MS_W-1:0] p_ms,
                            input logic [MS_W-1:0] z_ms, input logic [RATIO_W-1:0] ratio,
                            input logic a_start, input logic a_adv);
    pour_item_t it;
    it = random_item();
    it.cmd = CMD_WRITE;
    it.slot = slot;
    it.pour_ms = p_ms;
    it.pause_ms = z_ms;
    it.ratio = ratio;
    it.auto_start = a_start;
    it.auto_adv = a_adv;
    it.weight = random_weight();
    send_item(it);
  endtask

  task automatic send_command(input logic [1:0] c);
    pour_item_t it;
    it = random_item();
    it.cmd = c;
    it.weight = random_weight();
    send_item(it);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [COFFEE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Registers change only once the block has drained.
  task automatic apply_setting(input int steps, input logic [COFFEE_W-1:0] dose);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_POUR_COUNT, COFFEE_W'(steps));
    write_reg(CFG_COFFEE, dose);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // A restart, a few short table entries, then a run of ticks with time moving
  // forward in small steps, mixed with occasional noise.
  task automatic run_session();
    int n;
    logic [TIME_W-1:0] t;
    send_command(CMD_RESTART);
    for (int s = 0; s < MAX_POURS; s++) begin
      if ($urandom_range(0, 2) == 0)
        send_entry(s, $urandom_range(0, 40), $urandom_range(0, 30), $urandom,
                   $urandom_range(0, 1), $urandom_range(0, 1));
    end
    if ($urandom_range(0, 7) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 200);
    else t = $urandom;
    n = $urandom_range(8, 40);
    repeat (n) begin
      case ($urandom_range(0, 49))
        0, 1: send_entry($urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 1), $urandom_range(0, 1));
        2: send_command(CMD_UNUSED);
        3: send_command(CMD_RESTART);
        4: t = $urandom;
        default: ;
      endcase
      t += $urandom_range(0, 12);
      send_tick(t, $urandom_range(0, 5) == 0, random_weight());
    end
  endtask

  // Output side: a random stall before each transfer, and one long hold-off.
  initial begin
    int n;
    int got;
    out_stall = 1'b0;
    got = 0;
    forever begin
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        n = rx_quiet ? 0 : $urandom_range(0, 7);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got++;
      if (got % 50 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int start;
    int steps [PHASES];
    logic [COFFEE_W-1:0] dose;
    rst_n = 1'b0;
    in_valid = 1'b0;
    command = CMD_TICK;
    now_ms = '0;
    encoder_turned = 1'b0;
    encoder_click = 1'b0;
    weight_mg = '0;
    entry_index = '0;
    entry_pour_ms = '0;
    entry_pause_ms = '0;
    entry_ratio = '0;
    entry_auto_start = 1'b0;
    entry_auto_advance = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_POUR_COUNT;
    cfg_data = '0;
    steps = '{16, 1, 8, 0, 20, 3, 16};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_setting(4, 20'd18000);
    // Slot 0 is written first so that no readout ever uses an unwritten entry.
    send_entry(0, 24'd10, 24'd5, 16'd2000, 1'b0, 1'b0);
    send_entry(1, 24'd0, 24'd0, 16'hFFFF, 1'b1, 1'b1);
    send_entry(2, 24'hFFFFFF, 24'hFFFFFF, 16'd0, 1'b1, 1'b0);
    send_entry(3, 24'd3, 24'd0, 16'd1, 1'b0, 1'b1);
    for (int s = 4; s < MAX_POURS; s++)
      send_entry(s, $urandom, $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
    send_tick(32'd100, 1'b0, 24'sd0);        // waiting for a click
    send_tick(32'd100, 1'b1, 24'h800000);    // click starts, does not advance
    send_tick(32'd105, 1'b0, 24'h7FFFFF);
    send_tick(32'd112, 1'b0, 24'sd0);        // pause phase
    send_tick(32'd115, 1'b0, 24'sd1000);     // pour complete, buzzer
    send_tick(32'd116, 1'b0, -24'sd1);       // still complete, no second buzz
    send_tick(32'd117, 1'b1, 24'sd0);        // click advances
    send_tick(32'd118, 1'b0, 24'sd0);        // zero-length pour with auto-advance
    send_tick(32'd119, 1'b0, 24'sd0);        // long auto-started pour
    send_tick(32'd120, 1'b1, 24'sd0);        // click advances to the last pour
    send_tick(32'd121, 1'b1, 24'sd0);
    send_tick(32'd124, 1'b0, 24'sd0);        // last pour complete, auto-advance holds
    send_tick(32'd125, 1'b1, 24'sd0);        // click at the last pour holds
    send_command(CMD_UNUSED);
    send_command(CMD_RESTART);
    send_tick(32'hFFFF_FFFF, 1'b1, 24'sd0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, PHASES - 1: dose = '1;
        1:             dose = '0;
        default:       dose = $urandom;
      endcase
      apply_setting(steps[p], dose);
      start = sent;
      while (sent - start < PHASE_ITEMS) begin
        if (p == 1 && sent - start >= PHASE_ITEMS / 2) hold_go = 1'b1;
        run_session();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d items: %0d ticks, %0d table writes, %0d restarts, %0d unused commands",
             sent, n_ticks, n_writes, n_restarts, n_unused);
    $display("%0d register settings, %0d readouts compared, long output hold-off done: %0d",
             n_settings, checked, hold_done);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/pss_pkg.sv
sv/pour_step_sequencer_unit.sv
dv/pss_checker.sv
dv/tb.sv
